// ===== sv/rts_pkg.sv =====
// rts_pkg: widths, reset values, register indexes, codes and types for the
// resistive touch sampler; no dependencies
package rts_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int PRES_W     = 11;
    localparam int ADC_W      = 12;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;
    localparam int SC_CNT_W   = 4;

    localparam logic [ADC_W-1:0]    ADC_MAX = 12'd1023;
    localparam logic [SC_CNT_W-1:0] SC_LAST = SC_CNT_W'(SAMPLE_W - 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MIN   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RAW_MAX   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_RAW_MAX   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRES_THRESH = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOL  = 4'd7;

    // register reset values
    localparam logic [SAMPLE_W-1:0] X_RAW_MIN_RST   = 10'd125;
    localparam logic [SAMPLE_W-1:0] X_RAW_MAX_RST   = 10'd907;
    localparam logic [SAMPLE_W-1:0] Y_RAW_MIN_RST   = 10'd130;
    localparam logic [SAMPLE_W-1:0] Y_RAW_MAX_RST   = 10'd935;
    localparam logic [SAMPLE_W-1:0] SCREEN_W_RST    = 10'd319;
    localparam logic [SAMPLE_W-1:0] SCREEN_H_RST    = 10'd239;
    localparam logic [PRES_W-1:0]   PRES_THRESH_RST = 11'd200;
    localparam logic [SAMPLE_W-1:0] SETTLE_TOL_RST  = 10'd4;

    localparam logic FUNC_START = 1'b0;
    localparam logic CH_YPLUS   = 1'b0;
    localparam logic CH_XMINUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_P1, PH_P2, PH_X1, PH_X2, PH_Y1, PH_Y2
    } t_phase;

    typedef enum logic [MODE_W-1:0] {
        DRV_IDLE, DRV_PRESSURE, DRV_X, DRV_Y
    } t_drive;

    typedef enum logic [2:0] {
        CTL_RUN, CTL_X_START, CTL_X_WAIT, CTL_Y_START, CTL_Y_WAIT
    } t_ctl;

    typedef enum logic [1:0] {
        SC_IDLE, SC_MUL, SC_DIV, SC_DONE
    } t_sc_state;

    typedef struct packed {
        logic                start;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] size;
    } t_sc_req;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] result;
    } t_sc_rsp;

endpackage

// ===== sv/rts_if.sv =====
// rts_if: valid/ready channels for input items, results and register writes
// depends on rts_pkg
interface rts_in_if
    import rts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                func;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, func, sample, input ready);
    modport sink   (input valid, func, sample, output ready);
endinterface

interface rts_out_if
    import rts_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   drive_mode;
    logic                sample_channel;
    logic                done_res;
    logic                touched;
    logic [SAMPLE_W-1:0] x_pos;
    logic [SAMPLE_W-1:0] y_pos;
    logic [PRES_W-1:0]   pressure;

    modport source (output valid, drive_mode, sample_channel, done_res, touched,
                    x_pos, y_pos, pressure, input ready);
    modport sink   (input valid, drive_mode, sample_channel, done_res, touched,
                    x_pos, y_pos, pressure, output ready);
endinterface

interface rts_cfg_if
    import rts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/resistive_touch_sampler_top.sv =====
// resistive_touch_sampler_top: one result per item; result registered in the cycle after
// acceptance, except the item that settles the Y pair, whose result
// appears once both passes of the bit-serial scaler (X, then Y) finish;
// items are otherwise taken every cycle the result slot frees.
// synchronous active-low reset: idle phase, registers to defaults; rts_pkg, rts_if
module resistive_touch_sampler_top
    import rts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rts_in_if.sink    i_in,
    rts_out_if.source o_out,
    rts_cfg_if.sink   i_cfg
);

    logic [SAMPLE_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [SAMPLE_W-1:0] r_scr_w, r_scr_h, r_tol;
    logic [PRES_W-1:0]   r_thresh;

    t_phase              r_phase, n_phase;
    logic [SAMPLE_W-1:0] r_held, n_held;
    logic [PRES_W-1:0]   r_pvalue, n_pvalue;
    logic [SAMPLE_W-1:0] r_xavg, n_xavg;
    logic [SAMPLE_W-1:0] r_yraw, n_yraw;
    t_ctl                r_ctl, n_ctl;

    logic                r_out_valid;
    t_drive              r_out_mode;
    logic                r_out_chan, r_out_done, r_out_touch;
    logic [SAMPLE_W-1:0] r_out_x, r_out_y;
    logic [PRES_W-1:0]   r_out_pres;

    logic                in_fire, cfg_fire, fin, hit, use_y;
    t_drive              res_mode;
    logic                res_chan;
    logic [ADC_W+1:0]    p_raw;
    logic [PRES_W-1:0]   p_sat;
    logic [SAMPLE_W-1:0] diff;
    logic                pair_ok;
    logic [SAMPLE_W:0]   pair_sum;
    logic [SAMPLE_W-1:0] pair_avg;
    logic [ADC_W-1:0]    y_inv;
    logic [SAMPLE_W-1:0] y_clamp;

    t_sc_req             sc_req;
    t_sc_rsp             sc_rsp;

    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = (r_ctl == CTL_RUN) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min  <= X_RAW_MIN_RST;
            r_x_max  <= X_RAW_MAX_RST;
            r_y_min  <= Y_RAW_MIN_RST;
            r_y_max  <= Y_RAW_MAX_RST;
            r_scr_w  <= SCREEN_W_RST;
            r_scr_h  <= SCREEN_H_RST;
            r_thresh <= PRES_THRESH_RST;
            r_tol    <= SETTLE_TOL_RST;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                REG_X_RAW_MIN:   r_x_min  <= i_cfg.data[SAMPLE_W-1:0];
                REG_X_RAW_MAX:   r_x_max  <= i_cfg.data[SAMPLE_W-1:0];
                REG_Y_RAW_MIN:   r_y_min  <= i_cfg.data[SAMPLE_W-1:0];
                REG_Y_RAW_MAX:   r_y_max  <= i_cfg.data[SAMPLE_W-1:0];
                REG_SCREEN_W:    r_scr_w  <= i_cfg.data[SAMPLE_W-1:0];
                REG_SCREEN_H:    r_scr_h  <= i_cfg.data[SAMPLE_W-1:0];
                REG_PRES_THRESH: r_thresh <= i_cfg.data[PRES_W-1:0];
                REG_SETTLE_TOL:  r_tol    <= i_cfg.data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // pressure, pair check, averages
    assign p_raw = {2'b00, ADC_MAX} + (ADC_W+2)'(i_in.sample) - (ADC_W+2)'(r_held);
    assign p_sat = p_raw[ADC_W+1]           ? '0 :
                   (|p_raw[ADC_W:PRES_W])   ? '1 : p_raw[PRES_W-1:0];

    assign diff     = (r_held >= i_in.sample) ? r_held - i_in.sample
                                              : i_in.sample - r_held;
    assign pair_ok  = diff <= r_tol;
    assign pair_sum = {1'b0, r_held} + {1'b0, i_in.sample};
    assign pair_avg = pair_sum[SAMPLE_W:1];
    assign y_inv    = (ADC_MAX >= ADC_W'(pair_avg)) ? ADC_MAX - ADC_W'(pair_avg) : '0;
    assign y_clamp  = (|y_inv[ADC_W-1:SAMPLE_W]) ? '1 : y_inv[SAMPLE_W-1:0];

    // measurement sequencer, next state
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_pvalue = r_pvalue;
        n_xavg   = r_xavg;
        n_yraw   = r_yraw;
        fin      = 1'b0;
        hit      = 1'b0;
        if (in_fire) begin
            if (i_in.func == FUNC_START) begin
                n_phase  = PH_P1;
                n_pvalue = '0;
            end else begin
                case (r_phase)
                    PH_P1: begin
                        n_held  = i_in.sample;
                        n_phase = PH_P2;
                    end
                    PH_P2: begin
                        n_pvalue = p_sat;
                        if (p_sat >= r_thresh) begin
                            n_phase = PH_X1;
                        end else begin
                            n_phase = PH_IDLE;
                            fin     = 1'b1;
                        end
                    end
                    PH_X1: begin
                        n_held  = i_in.sample;
                        n_phase = PH_X2;
                    end
                    PH_X2: begin
                        if (pair_ok) begin
                            n_xavg  = pair_avg;
                            n_phase = PH_Y1;
                        end else begin
                            n_phase = PH_X1;
                        end
                    end
                    PH_Y1: begin
                        n_held  = i_in.sample;
                        n_phase = PH_Y2;
                    end
                    PH_Y2: begin
                        if (pair_ok) begin
                            n_yraw  = y_clamp;
                            n_phase = PH_IDLE;
                            fin     = 1'b1;
                            hit     = 1'b1;
                        end else begin
                            n_phase = PH_Y1;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    // measurement sequencer, outputs
    always_comb begin
        case (n_phase)
            PH_P1:        begin res_mode = DRV_PRESSURE; res_chan = CH_YPLUS;  end
            PH_P2:        begin res_mode = DRV_PRESSURE; res_chan = CH_XMINUS; end
            PH_X1, PH_X2: begin res_mode = DRV_X;        res_chan = CH_YPLUS;  end
            PH_Y1, PH_Y2: begin res_mode = DRV_Y;        res_chan = CH_XMINUS; end
            default:      begin res_mode = DRV_IDLE;     res_chan = CH_YPLUS;  end
        endcase
    end

    // scaling control, next state
    always_comb begin
        n_ctl = r_ctl;
        case (r_ctl)
            CTL_RUN:     if (in_fire && hit) n_ctl = CTL_X_START;
            CTL_X_START: n_ctl = CTL_X_WAIT;
            CTL_X_WAIT:  if (sc_rsp.done) n_ctl = CTL_Y_START;
            CTL_Y_START: n_ctl = CTL_Y_WAIT;
            CTL_Y_WAIT:  if (sc_rsp.done) n_ctl = CTL_RUN;
            default:     n_ctl = CTL_RUN;
        endcase
    end

    // scaling control, outputs
    always_comb begin
        use_y        = (r_ctl == CTL_Y_START) || (r_ctl == CTL_Y_WAIT);
        sc_req.start = (r_ctl == CTL_X_START) || (r_ctl == CTL_Y_START);
        sc_req.v     = use_y ? r_yraw  : r_xavg;
        sc_req.lo    = use_y ? r_y_min : r_x_min;
        sc_req.hi    = use_y ? r_y_max : r_x_max;
        sc_req.size  = use_y ? r_scr_h : r_scr_w;
    end

    rts_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sc_req),
        .o_rsp   (sc_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_held      <= '0;
            r_pvalue    <= '0;
            r_xavg      <= '0;
            r_yraw      <= '0;
            r_ctl       <= CTL_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_pvalue <= n_pvalue;
            r_xavg   <= n_xavg;
            r_yraw   <= n_yraw;
            r_ctl    <= n_ctl;
            if (in_fire) begin
                r_out_valid <= !hit;
            end else if (r_ctl == CTL_Y_WAIT && sc_rsp.done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_mode  <= res_mode;
            r_out_chan  <= res_chan;
            r_out_done  <= fin;
            r_out_touch <= hit;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_pres  <= n_pvalue;
        end else if (r_ctl == CTL_X_WAIT && sc_rsp.done) begin
            r_out_x <= sc_rsp.result;
        end else if (r_ctl == CTL_Y_WAIT && sc_rsp.done) begin
            r_out_y <= sc_rsp.result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.drive_mode     = r_out_mode;
    assign o_out.sample_channel = r_out_chan;
    assign o_out.done_res       = r_out_done;
    assign o_out.touched        = r_out_touch;
    assign o_out.x_pos          = r_out_x;
    assign o_out.y_pos          = r_out_y;
    assign o_out.pressure       = r_out_pres;

`ifndef SYNTHESIS
    a_scale_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && hit) |=> (r_ctl == CTL_X_START) && !r_out_valid)
        else $error("settled y pair did not start scaling");

    a_scale_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == CTL_Y_WAIT && sc_rsp.done) |=> r_out_valid && r_out_touch)
        else $error("scaled result not presented");

    a_touch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_touch || r_out_done))
        else $error("touch reported without measurement end");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |-> (r_out_mode == DRV_IDLE))
        else $error("finished measurement with drive pattern active");
`endif

endmodule

// ===== sv/rts_scaler.sv =====
// rts_scaler: bit-serial linear scaling (v - lo) * size / (hi - lo) with clamping
// shift-add multiply then restoring divide, one bit per cycle; depends on rts_pkg
module rts_scaler
    import rts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sc_req i_req,
    output t_sc_rsp o_rsp
);

    t_sc_state           r_state, n_state;
    logic [SC_CNT_W-1:0] r_cnt;
    logic [SAMPLE_W-1:0] r_hi, r_lo, r_size, r_div, r_res;

    logic [SAMPLE_W:0]   mul_sum;
    logic [SAMPLE_W:0]   div_trial;
    logic [SAMPLE_W:0]   div_rem;
    logic                div_ge;
    logic                trivial_zero, trivial_full;

    assign mul_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_size} : '0);
    assign div_trial = {r_hi, r_lo[SAMPLE_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div};
    assign div_rem   = div_ge ? div_trial - {1'b0, r_div} : div_trial;

    assign trivial_zero = (i_req.hi <= i_req.lo) || (i_req.v <= i_req.lo);
    assign trivial_full = i_req.v >= i_req.hi;

    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    n_state = (trivial_zero || trivial_full) ? SC_DONE : SC_MUL;
                end
            end
            SC_MUL: begin
                if (r_cnt == SC_LAST) n_state = SC_DIV;
            end
            SC_DIV: begin
                if (r_cnt == SC_LAST) n_state = SC_DONE;
            end
            SC_DONE: n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done   = (r_state == SC_DONE);
        o_rsp.result = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == SC_MUL || r_state == SC_DIV) begin
                r_cnt <= (r_cnt == SC_LAST) ? '0 : r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                if (i_req.start) begin
                    r_size <= i_req.size;
                    r_hi   <= '0;
                    r_lo   <= i_req.v - i_req.lo;
                    r_div  <= i_req.hi - i_req.lo;
                    r_res  <= trivial_zero ? '0 : i_req.size;
                end
            end
            SC_MUL: begin
                r_hi <= mul_sum[SAMPLE_W:1];
                r_lo <= {mul_sum[0], r_lo[SAMPLE_W-1:1]};
            end
            SC_DIV: begin
                r_hi <= div_rem[SAMPLE_W-1:0];
                r_lo <= {r_lo[SAMPLE_W-2:0], div_ge};
                if (r_cnt == SC_LAST) r_res <= {r_lo[SAMPLE_W-2:0], div_ge};
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("scaler done held for more than one cycle");

    a_result_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> (r_res <= r_size))
        else $error("scaled value above screen size");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SC_DIV) |-> (r_hi < r_div))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench for resistive_touch_sampler_top: directed table then random touch
// measurements, results checked against an in-bench predictor of the sequencer
// depends on rts_pkg, rts_if and the top level
`timescale 1ns / 1ps

module testbench;
    import rts_pkg::*;

    typedef struct packed {
        t_drive              drive_mode;
        logic                sample_channel;
        logic                done_res;
        logic                touched;
        logic [SAMPLE_W-1:0] x_pos;
        logic [SAMPLE_W-1:0] y_pos;
        logic [PRES_W-1:0]   pressure;
    } t_touch_result;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] sample;
        logic                fixed_want;
        t_touch_result       want;
    } t_stim_row;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_PHASE      = 4;
    localparam int IDLE_LIMIT      = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_WAIT     = 4;
    localparam int END_WAIT        = 60;
    localparam int SAMPLE_TOP      = (1 << SAMPLE_W) - 1;
    localparam int PRES_TOP        = 2 * SAMPLE_TOP;
    localparam int PRES_SAT        = (1 << PRES_W) - 1;

    localparam logic FUNC_RESULT = ~FUNC_START;
    localparam logic [CFG_IDX_W-1:0]  REG_FIRST_UNUSED = 4'd8;
    localparam logic [CFG_DATA_W-1:0] CFG_HIGH_BIT     = 11'h400;
    localparam t_touch_result NOT_TYPED = '0;

    logic clk = 1'b0;
    logic rst_n;

    rts_in_if  in_ch ();
    rts_out_if out_ch ();
    rts_cfg_if cfg_ch ();

    resistive_touch_sampler_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state and calibration copy
    t_phase              sampler_phase = PH_IDLE;
    logic [SAMPLE_W-1:0] held_value    = '0;
    logic [PRES_W-1:0]   meas_pressure = '0;
    logic [SAMPLE_W-1:0] x_mean        = '0;

    logic [SAMPLE_W-1:0] cal_x_lo     = X_RAW_MIN_RST;
    logic [SAMPLE_W-1:0] cal_x_hi     = X_RAW_MAX_RST;
    logic [SAMPLE_W-1:0] cal_y_lo     = Y_RAW_MIN_RST;
    logic [SAMPLE_W-1:0] cal_y_hi     = Y_RAW_MAX_RST;
    logic [SAMPLE_W-1:0] scr_w        = SCREEN_W_RST;
    logic [SAMPLE_W-1:0] scr_h        = SCREEN_H_RST;
    logic [PRES_W-1:0]   touch_thresh = PRES_THRESH_RST;
    logic [SAMPLE_W-1:0] pair_tol     = SETTLE_TOL_RST;

    t_touch_result pending_results[$];
    int fail_count    = 0;
    int measure_items = 0;
    int idle_cycles   = 0;
    bit calm          = 1'b0;
    bit hold_req      = 1'b0;

    t_stim_row directed_rows [26] = '{
        '{FUNC_RESULT, 10'd1023, 1'b1,
          '{DRV_IDLE, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd0}},
        '{FUNC_START, 10'd0, 1'b1,
          '{DRV_PRESSURE, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd0}},
        '{FUNC_RESULT, 10'd1023, 1'b1,
          '{DRV_PRESSURE, CH_XMINUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd0}},
        '{FUNC_RESULT, 10'd0, 1'b1,
          '{DRV_IDLE, CH_YPLUS, 1'b1, 1'b0, 10'd0, 10'd0, 11'd0}},
        '{FUNC_START, 10'd1023, 1'b1,
          '{DRV_PRESSURE, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd0}},
        '{FUNC_RESULT, 10'd0, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b1,
          '{DRV_X, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd2046}},
        '{FUNC_RESULT, 10'd100, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd110, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd100, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd104, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd500, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd510, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b1,
          '{DRV_IDLE, CH_YPLUS, 1'b1, 1'b1, 10'd0, 10'd0, 11'd2046}},
        '{FUNC_START, 10'd0, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd0, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd1023, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd0, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd0, 1'b1,
          '{DRV_IDLE, CH_YPLUS, 1'b1, 1'b1, 10'd319, 10'd239, 11'd2046}},
        '{FUNC_START, 10'd0, 1'b0, NOT_TYPED},
        '{FUNC_RESULT, 10'd823, 1'b0, NOT_TYPED},
        // pressure exactly at threshold counts as touch
        '{FUNC_RESULT, 10'd0, 1'b1,
          '{DRV_X, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd200}},
        // start while busy
        '{FUNC_START, 10'd5, 1'b1,
          '{DRV_PRESSURE, CH_YPLUS, 1'b0, 1'b0, 10'd0, 10'd0, 11'd0}}
    };

    function automatic logic [SAMPLE_W-1:0] scale_axis(input logic [SAMPLE_W-1:0] v,
                                                       input logic [SAMPLE_W-1:0] lo,
                                                       input logic [SAMPLE_W-1:0] hi,
                                                       input logic [SAMPLE_W-1:0] size);
        if (hi <= lo || v <= lo) return '0;
        if (v >= hi) return size;
        return SAMPLE_W'((int'(v) - int'(lo)) * int'(size) / (int'(hi) - int'(lo)));
    endfunction

    function automatic bit pair_settled(input logic [SAMPLE_W-1:0] a,
                                        input logic [SAMPLE_W-1:0] b);
        int diff;
        diff = (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return diff <= int'(pair_tol);
    endfunction

    task automatic predict_touch_result(input logic f, input logic [SAMPLE_W-1:0] s,
                                        output t_touch_result r);
        int p;
        int avg;
        int y_raw;
        r = '0;
        r.drive_mode = DRV_IDLE;
        r.sample_channel = CH_YPLUS;
        if (f == FUNC_START) begin
            sampler_phase = PH_P1;
            meas_pressure = '0;
            r.drive_mode = DRV_PRESSURE;
        end else begin
            case (sampler_phase)
                PH_P1: begin
                    held_value = s;
                    sampler_phase = PH_P2;
                    r.drive_mode = DRV_PRESSURE;
                    r.sample_channel = CH_XMINUS;
                end
                PH_P2: begin
                    p = int'(ADC_MAX) - (int'(held_value) - int'(s));
                    if (p < 0) p = 0;
                    if (p > PRES_SAT) p = PRES_SAT;
                    meas_pressure = PRES_W'(p);
                    if (meas_pressure < touch_thresh) begin
                        sampler_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end else begin
                        sampler_phase = PH_X1;
                        r.drive_mode = DRV_X;
                    end
                end
                PH_X1: begin
                    held_value = s;
                    sampler_phase = PH_X2;
                    r.drive_mode = DRV_X;
                end
                PH_X2: begin
                    if (pair_settled(held_value, s)) begin
                        x_mean = SAMPLE_W'((int'(held_value) + int'(s)) >> 1);
                        sampler_phase = PH_Y1;
                        r.drive_mode = DRV_Y;
                        r.sample_channel = CH_XMINUS;
                    end else begin
                        sampler_phase = PH_X1;
                        r.drive_mode = DRV_X;
                    end
                end
                PH_Y1: begin
                    held_value = s;
                    sampler_phase = PH_Y2;
                    r.drive_mode = DRV_Y;
                    r.sample_channel = CH_XMINUS;
                end
                PH_Y2: begin
                    if (pair_settled(held_value, s)) begin
                        avg = (int'(held_value) + int'(s)) >> 1;
                        y_raw = (int'(ADC_MAX) >= avg) ? int'(ADC_MAX) - avg : 0;
                        r.x_pos = scale_axis(x_mean, cal_x_lo, cal_x_hi, scr_w);
                        r.y_pos = scale_axis(SAMPLE_W'(y_raw), cal_y_lo, cal_y_hi, scr_h);
                        sampler_phase = PH_IDLE;
                        r.done_res = 1'b1;
                        r.touched = 1'b1;
                    end else begin
                        sampler_phase = PH_Y1;
                        r.drive_mode = DRV_Y;
                        r.sample_channel = CH_XMINUS;
                    end
                end
                default: sampler_phase = PH_IDLE;
            endcase
        end
        r.pressure = meas_pressure;
    endtask

    task automatic send_item(input logic f, input logic [SAMPLE_W-1:0] s,
                             input logic use_want = 1'b0,
                             input t_touch_result want = NOT_TYPED);
        t_touch_result got;
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.func   <= f;
        in_ch.sample <= s;
        do @(posedge clk); while (!in_ch.ready);
        if (!(f == FUNC_RESULT && sampler_phase == PH_IDLE)) measure_items++;
        predict_touch_result(f, s, got);
        pending_results.push_back(use_want ? want : got);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_X_RAW_MIN:   cal_x_lo = data[SAMPLE_W-1:0];
            REG_X_RAW_MAX:   cal_x_hi = data[SAMPLE_W-1:0];
            REG_Y_RAW_MIN:   cal_y_lo = data[SAMPLE_W-1:0];
            REG_Y_RAW_MAX:   cal_y_hi = data[SAMPLE_W-1:0];
            REG_SCREEN_W:    scr_w = data[SAMPLE_W-1:0];
            REG_SCREEN_H:    scr_h = data[SAMPLE_W-1:0];
            REG_PRES_THRESH: touch_thresh = data[PRES_W-1:0];
            REG_SETTLE_TOL:  pair_tol = data[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [CFG_DATA_W-1:0] x_lo, x_hi, y_lo, y_hi,
                                 input logic [CFG_DATA_W-1:0] w, h, thr, tol);
        write_reg(REG_X_RAW_MIN, x_lo);
        write_reg(REG_X_RAW_MAX, x_hi);
        write_reg(REG_Y_RAW_MIN, y_lo);
        write_reg(REG_Y_RAW_MAX, y_hi);
        write_reg(REG_SCREEN_W, w);
        write_reg(REG_SCREEN_H, h);
        write_reg(REG_PRES_THRESH, thr);
        write_reg(REG_SETTLE_TOL, tol);
        // unlisted index must be ignored
        write_reg(REG_FIRST_UNUSED | CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // sample pairs on one axis until the pair settles, or abandon with a start
    task automatic send_axis(output bit aborted);
        t_phase first;
        int a;
        int b;
        int tol;
        bit up_ok;
        bit down_ok;
        aborted = 1'b0;
        first = sampler_phase;
        tol = int'(pair_tol);
        do begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(FUNC_START, SAMPLE_W'($urandom));
                aborted = 1'b1;
                return;
            end
            a = $urandom_range(0, SAMPLE_TOP);
            up_ok = (a + tol + 1 <= SAMPLE_TOP);
            down_ok = (a - tol - 1 >= 0);
            if ((!up_ok && !down_ok) || $urandom_range(0, 1) == 0)
                b = $urandom_range((a - tol < 0) ? 0 : a - tol,
                                   (a + tol > SAMPLE_TOP) ? SAMPLE_TOP : a + tol);
            else if (up_ok && (!down_ok || $urandom_range(0, 1) == 0))
                b = $urandom_range(a + tol + 1, SAMPLE_TOP);
            else
                b = $urandom_range(0, a - tol - 1);
            send_item(FUNC_RESULT, SAMPLE_W'(a));
            send_item(FUNC_RESULT, SAMPLE_W'(b));
        end while (sampler_phase == first);
    endtask

    task automatic run_measurement();
        int p;
        int d;
        int s1;
        int thr;
        bit aborted;
        if (sampler_phase == PH_IDLE && $urandom_range(0, 11) == 0) begin
            send_item(FUNC_RESULT, SAMPLE_W'($urandom));
            return;
        end
        send_item(FUNC_START, SAMPLE_W'($urandom));
        if ($urandom_range(0, 39) == 0) return;
        thr = int'(touch_thresh);
        if (thr > 0 && $urandom_range(0, 4) == 0) p = $urandom_range(0, thr - 1);
        else p = $urandom_range(thr, PRES_TOP);
        d = p - SAMPLE_TOP;
        if (d >= 0) s1 = $urandom_range(0, SAMPLE_TOP - d);
        else s1 = $urandom_range(-d, SAMPLE_TOP);
        send_item(FUNC_RESULT, SAMPLE_W'(s1));
        send_item(FUNC_RESULT, SAMPLE_W'(s1 + d));
        if (sampler_phase == PH_IDLE) return;
        send_axis(aborted);
        if (aborted) return;
        send_axis(aborted);
    endtask

    // settled pairs always end the measurement
    task automatic close_measurement();
        while (sampler_phase != PH_IDLE) begin
            if (sampler_phase == PH_X2 || sampler_phase == PH_Y2)
                send_item(FUNC_RESULT, held_value);
            else
                send_item(FUNC_RESULT, SAMPLE_W'($urandom));
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [PRES_W-1:0] want,
                                 input logic [PRES_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_touch_result want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("drive_mode", PRES_W'(want.drive_mode), PRES_W'(out_ch.drive_mode));
                compare_field("sample_channel", PRES_W'(want.sample_channel),
                              PRES_W'(out_ch.sample_channel));
                compare_field("done_res", PRES_W'(want.done_res), PRES_W'(out_ch.done_res));
                compare_field("touched", PRES_W'(want.touched), PRES_W'(out_ch.touched));
                compare_field("x_pos", PRES_W'(want.x_pos), PRES_W'(out_ch.x_pos));
                compare_field("y_pos", PRES_W'(want.y_pos), PRES_W'(out_ch.y_pos));
                compare_field("pressure", want.pressure, out_ch.pressure);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin
        int phase_start;
        logic [CFG_DATA_W-1:0] x_lo, x_hi, y_lo, y_hi, tmp;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.func   <= FUNC_START;
        in_ch.sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].func, directed_rows[i].sample,
                      directed_rows[i].fixed_want, directed_rows[i].want);
        close_measurement();
        wait_results_drained();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph)
                1: apply_setting(11'(X_RAW_MIN_RST), 11'(X_RAW_MAX_RST), 11'(Y_RAW_MIN_RST),
                                 11'(Y_RAW_MAX_RST), 11'(SCREEN_W_RST), 11'(SCREEN_H_RST),
                                 PRES_THRESH_RST, 11'(SETTLE_TOL_RST));
                2: apply_setting(11'd0, 11'd1023, 11'd0, 11'd1023, 11'd1023, 11'd1023,
                                 11'd0, 11'd0);
                // empty windows, smallest screen, highest threshold
                3: apply_setting(11'd1023, 11'd0, 11'd512, 11'd512, 11'd1, 11'd1,
                                 11'd2046, 11'd1023);
                // upper data bit must be dropped on the narrow registers
                4: apply_setting(CFG_HIGH_BIT | 11'd300, CFG_HIGH_BIT | 11'd700,
                                 CFG_HIGH_BIT | 11'd200, CFG_HIGH_BIT | 11'd800,
                                 CFG_HIGH_BIT | 11'd500, CFG_HIGH_BIT | 11'd400,
                                 11'd600, CFG_HIGH_BIT | 11'd8);
                default: begin
                    x_lo = 11'($urandom_range(0, SAMPLE_TOP));
                    x_hi = 11'($urandom_range(0, SAMPLE_TOP));
                    if (x_lo > x_hi && $urandom_range(0, 4) != 0) begin
                        tmp = x_lo; x_lo = x_hi; x_hi = tmp;
                    end
                    y_lo = 11'($urandom_range(0, SAMPLE_TOP));
                    y_hi = 11'($urandom_range(0, SAMPLE_TOP));
                    if (y_lo > y_hi && $urandom_range(0, 4) != 0) begin
                        tmp = y_lo; y_lo = y_hi; y_hi = tmp;
                    end
                    apply_setting(x_lo, x_hi, y_lo, y_hi,
                                  11'($urandom_range(1, SAMPLE_TOP)),
                                  11'($urandom_range(1, SAMPLE_TOP)),
                                  ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, PRES_TOP))
                                                              : 11'($urandom_range(0, 1100)),
                                  ($urandom_range(0, 1) == 0) ? 11'($urandom_range(0, 15))
                                                              : 11'($urandom_range(0, SAMPLE_TOP)));
                end
            endcase
            if (ph == HOLD_PHASE) hold_req = 1'b1;
            if (ph == NUM_PHASES) calm = 1'b1;
            phase_start = measure_items;
            while (measure_items - phase_start < ITEMS_PER_PHASE) run_measurement();
            close_measurement();
            wait_results_drained();
        end

        repeat (END_WAIT) @(posedge clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
